[rtl/rmq_pkg.sv]
// rmq_pkg: shared constants and types for the rotation matrix to quaternion block
// used by rmq_sqrt_cell, rmq_div_cell and rotation_matrix_to_quaternion
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ELEM_W    = 16;
  localparam int ARG_W     = 17;                     // clamped square-root argument
  localparam int RAD_W     = 2 * ((ARG_W + FRAC_BITS + 1) / 2);
  localparam int SQ_STEPS  = RAD_W / 2;              // one root bit per cell
  localparam int ROOT_W    = SQ_STEPS;
  localparam int REM_W     = ROOT_W + 4;
  localparam int PIV_W     = ROOT_W - 1;
  localparam int MAG_W     = ELEM_W + 1;
  localparam int DIVS_W    = PIV_W + 2;              // divisor is four times the pivot
  localparam int DVD_W     = MAG_W + FRAC_BITS;
  localparam int DV_STEPS  = DVD_W;                  // one quotient bit per cell
  localparam int LANES     = 3;
  localparam logic [DVD_W-1:0] ONE = DVD_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    PC_TRACE = 2'd0,
    PC_X     = 2'd1,
    PC_Y     = 2'd2,
    PC_Z     = 2'd3
  } pivot_t;

  // side data riding along the square-root cells
  typedef struct packed {
    logic                        valid;
    pivot_t                      pc;
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
  } sq_side_t;

  // side data riding along the divider cells
  typedef struct packed {
    logic             valid;
    pivot_t           pc;
    logic             bad;
    logic [PIV_W-1:0] piv;
    logic [LANES-1:0] neg;
  } dv_side_t;

endpackage

[rtl/rmq_sqrt_cell.sv]
// rmq_sqrt_cell: one step of the restoring integer square root, one root bit per word
// depends on rmq_pkg
module rmq_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [rmq_pkg::REM_W-1:0]     rem_in,
  input  logic [rmq_pkg::ROOT_W-1:0]    root_in,
  input  logic [rmq_pkg::RAD_W-1:0]     rad_in,
  input  rmq_pkg::sq_side_t             side_in,
  output logic [rmq_pkg::REM_W-1:0]     rem,
  output logic [rmq_pkg::ROOT_W-1:0]    root,
  output logic [rmq_pkg::RAD_W-1:0]     rad,
  output rmq_pkg::sq_side_t             side
);

  logic [rmq_pkg::REM_W-1:0]  rem_sh;
  logic [rmq_pkg::REM_W-1:0]  trial;
  logic [rmq_pkg::REM_W-1:0]  rem_next;
  logic [rmq_pkg::ROOT_W-1:0] root_next;

  always_comb begin
    rem_sh = {rem_in[rmq_pkg::REM_W-3:0], rad_in[rmq_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root_in, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root_in[rmq_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root_in[rmq_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem        <= rem_next;
      root       <= root_next;
      rad        <= {rad_in[rmq_pkg::RAD_W-3:0], 2'b00};
      side.pc    <= side_in.pc;
      side.mag   <= side_in.mag;
      side.neg   <= side_in.neg;
    end
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= side_in.valid;
    end
  end

endmodule

[rtl/rmq_div_cell.sv]
// rmq_div_cell: one restoring division step for three lanes sharing one divisor
// depends on rmq_pkg
module rmq_div_cell (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::DIVS_W-1:0] rem_in,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::DVD_W-1:0]  dvd_in,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::DVD_W-1:0]  quo_in,
  input  rmq_pkg::dv_side_t                           side_in,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::DIVS_W-1:0] rem,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::DVD_W-1:0]  dvd,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::DVD_W-1:0]  quo,
  output rmq_pkg::dv_side_t                           side
);

  logic [rmq_pkg::DIVS_W:0]                           divisor;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::DIVS_W:0]       rem_sh;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::DIVS_W:0]       diff;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::DIVS_W-1:0]     rem_next;
  logic [rmq_pkg::LANES-1:0]                          qbit;

  always_comb begin
    divisor = {1'b0, side_in.piv, 2'b00};
    for (int i = 0; i < rmq_pkg::LANES; i++) begin
      rem_sh[i] = {rem_in[i], dvd_in[i][rmq_pkg::DVD_W-1]};
      diff[i]   = rem_sh[i] - divisor;
      qbit[i]   = (rem_sh[i] >= divisor);
      rem_next[i] = qbit[i] ? diff[i][rmq_pkg::DIVS_W-1:0]
                            : rem_sh[i][rmq_pkg::DIVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
        rem[i] <= rem_next[i];
        dvd[i] <= {dvd_in[i][rmq_pkg::DVD_W-2:0], 1'b0};
        quo[i] <= {quo_in[i][rmq_pkg::DVD_W-2:0], qbit[i]};
      end
      side.pc  <= side_in.pc;
      side.bad <= side_in.bad;
      side.piv <= side_in.piv;
      side.neg <= side_in.neg;
    end
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= side_in.valid;
    end
  end

endmodule

[rtl/rotation_matrix_to_quaternion.sv]
// rotation_matrix_to_quaternion: Shepperd matrix to quaternion, pipelined
// chain of 16 square-root cells then 31 divider cells, one bit per cell
// throughput one word per cycle; the whole chain holds while out_stall is high
// and a finished word waits, so in_stall follows out_stall in that case
// rst (synchronous, active high) clears the valid bits of every cell
// depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell
module rotation_matrix_to_quaternion (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] r00,
  input  logic signed [15:0] r01,
  input  logic signed [15:0] r02,
  input  logic signed [15:0] r10,
  input  logic signed [15:0] r11,
  input  logic signed [15:0] r12,
  input  logic signed [15:0] r20,
  input  logic signed [15:0] r21,
  input  logic signed [15:0] r22,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] qx,
  output logic signed [15:0] qy,
  output logic signed [15:0] qz,
  output logic signed [15:0] qw,
  output logic [1:0]  pivot_case,
  output logic        bad_input
);

  localparam int SQ_N = rmq_pkg::SQ_STEPS;
  localparam int DV_N = rmq_pkg::DV_STEPS;
  localparam int L    = rmq_pkg::LANES;

  logic en;

  // front end
  logic signed [18:0] trace;
  logic signed [18:0] arg_s;
  logic signed [17:0] s0;
  logic signed [17:0] s1;
  logic signed [17:0] s2;
  logic signed [rmq_pkg::MAG_W-1:0] d [L];
  rmq_pkg::pivot_t   pc_in;
  logic [rmq_pkg::ARG_W-1:0] arg;
  rmq_pkg::sq_side_t sq_side_in;

  // chains
  logic [rmq_pkg::REM_W-1:0]  sq_rem  [SQ_N+1];
  logic [rmq_pkg::ROOT_W-1:0] sq_root [SQ_N+1];
  logic [rmq_pkg::RAD_W-1:0]  sq_rad  [SQ_N+1];
  rmq_pkg::sq_side_t          sq_side [SQ_N+1];

  logic [L-1:0][rmq_pkg::DIVS_W-1:0] dv_rem [DV_N+1];
  logic [L-1:0][rmq_pkg::DVD_W-1:0]  dv_dvd [DV_N+1];
  logic [L-1:0][rmq_pkg::DVD_W-1:0]  dv_quo [DV_N+1];
  rmq_pkg::dv_side_t                 dv_side [DV_N+1];

  // back end
  rmq_pkg::dv_side_t         fin;
  logic [rmq_pkg::DVD_W-1:0] mag_sat [L];
  logic signed [15:0]        lane_q  [L];
  logic signed [15:0]        piv_q;
  logic signed [15:0]        q [4];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    trace = 19'(r00) + 19'(r11) + 19'(r22);
    s0    = 18'(r00) - 18'(r11);
    s1    = 18'(r11) - 18'(r22);
    s2    = 18'(r00) - 18'(r22);
    if (trace > 0) begin
      pc_in = rmq_pkg::PC_TRACE;
      arg_s = trace + 19'(1 << rmq_pkg::FRAC_BITS);
    end else if (s0 > 0 && s2 > 0) begin
      pc_in = rmq_pkg::PC_X;
      arg_s = 19'(r00) - 19'(r11) - 19'(r22) + 19'(1 << rmq_pkg::FRAC_BITS);
    end else if (s1 > 0) begin
      pc_in = rmq_pkg::PC_Y;
      arg_s = 19'(r11) - 19'(r00) - 19'(r22) + 19'(1 << rmq_pkg::FRAC_BITS);
    end else begin
      pc_in = rmq_pkg::PC_Z;
      arg_s = 19'(r22) - 19'(r00) - 19'(r11) + 19'(1 << rmq_pkg::FRAC_BITS);
    end
    arg = arg_s[18] ? '0 : arg_s[rmq_pkg::ARG_W-1:0];

    // lanes fill the non-pivot components in x, y, z, w order
    unique case (pc_in)
      rmq_pkg::PC_TRACE: begin
        d[0] = 17'(r21) - 17'(r12);
        d[1] = 17'(r02) - 17'(r20);
        d[2] = 17'(r10) - 17'(r01);
      end
      rmq_pkg::PC_X: begin
        d[0] = 17'(r10) + 17'(r01);
        d[1] = 17'(r02) + 17'(r20);
        d[2] = 17'(r21) - 17'(r12);
      end
      rmq_pkg::PC_Y: begin
        d[0] = 17'(r10) + 17'(r01);
        d[1] = 17'(r21) + 17'(r12);
        d[2] = 17'(r02) - 17'(r20);
      end
      default: begin
        d[0] = 17'(r02) + 17'(r20);
        d[1] = 17'(r21) + 17'(r12);
        d[2] = 17'(r10) - 17'(r01);
      end
    endcase

    sq_side_in.valid = in_valid;
    sq_side_in.pc    = pc_in;
    for (int i = 0; i < L; i++) begin
      sq_side_in.neg[i] = d[i][rmq_pkg::MAG_W-1];
      sq_side_in.mag[i] = d[i][rmq_pkg::MAG_W-1] ? rmq_pkg::MAG_W'(-d[i])
                                                  : rmq_pkg::MAG_W'(d[i]);
    end
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {{(rmq_pkg::RAD_W - rmq_pkg::ARG_W - rmq_pkg::FRAC_BITS){1'b0}},
                       arg, {rmq_pkg::FRAC_BITS{1'b0}}};
  assign sq_side[0] = sq_side_in;

  for (genvar g = 0; g < SQ_N; g++) begin : g_sq
    rmq_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .rem_in  (sq_rem[g]),
      .root_in (sq_root[g]),
      .rad_in  (sq_rad[g]),
      .side_in (sq_side[g]),
      .rem     (sq_rem[g+1]),
      .root    (sq_root[g+1]),
      .rad     (sq_rad[g+1]),
      .side    (sq_side[g+1])
    );
  end

  // pivot is half the root, truncated
  always_comb begin
    dv_side[0].valid = sq_side[SQ_N].valid;
    dv_side[0].pc    = sq_side[SQ_N].pc;
    dv_side[0].piv   = sq_root[SQ_N][rmq_pkg::ROOT_W-1:1];
    dv_side[0].bad   = (sq_root[SQ_N][rmq_pkg::ROOT_W-1:1] == '0);
    dv_side[0].neg   = sq_side[SQ_N].neg;
    for (int i = 0; i < L; i++) begin
      dv_rem[0][i] = '0;
      dv_quo[0][i] = '0;
      dv_dvd[0][i] = {sq_side[SQ_N].mag[i], {rmq_pkg::FRAC_BITS{1'b0}}};
    end
  end

  for (genvar g = 0; g < DV_N; g++) begin : g_dv
    rmq_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .rem_in  (dv_rem[g]),
      .dvd_in  (dv_dvd[g]),
      .quo_in  (dv_quo[g]),
      .side_in (dv_side[g]),
      .rem     (dv_rem[g+1]),
      .dvd     (dv_dvd[g+1]),
      .quo     (dv_quo[g+1]),
      .side    (dv_side[g+1])
    );
  end

  assign fin = dv_side[DV_N];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      mag_sat[i] = (dv_quo[DV_N][i] > rmq_pkg::ONE) ? rmq_pkg::ONE : dv_quo[DV_N][i];
      lane_q[i]  = fin.neg[i] ? -16'(mag_sat[i]) : 16'(mag_sat[i]);
    end
    piv_q = ({1'b0, fin.piv} > (rmq_pkg::PIV_W+1)'(rmq_pkg::ONE))
            ? 16'(rmq_pkg::ONE) : 16'(fin.piv);
    unique case (fin.pc)
      rmq_pkg::PC_TRACE: begin
        q[0] = lane_q[0]; q[1] = lane_q[1]; q[2] = lane_q[2]; q[3] = piv_q;
      end
      rmq_pkg::PC_X: begin
        q[0] = piv_q; q[1] = lane_q[0]; q[2] = lane_q[1]; q[3] = lane_q[2];
      end
      rmq_pkg::PC_Y: begin
        q[0] = lane_q[0]; q[1] = piv_q; q[2] = lane_q[1]; q[3] = lane_q[2];
      end
      default: begin
        q[0] = lane_q[0]; q[1] = lane_q[1]; q[2] = piv_q; q[3] = lane_q[2];
      end
    endcase
    if (fin.bad) begin
      for (int k = 0; k < 4; k++) q[k] = '0;
    end
  end

  assign out_valid  = fin.valid;
  assign qx         = q[0];
  assign qy         = q[1];
  assign qz         = q[2];
  assign qw         = q[3];
  assign pivot_case = fin.pc;
  assign bad_input  = fin.bad;

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_input |-> qx == 0 && qy == 0 && qz == 0 && qw == 0)
    else $error("bad word carries nonzero components");

  a_trace_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_input && pivot_case == rmq_pkg::PC_TRACE |-> qw > 0)
    else $error("trace branch pivot not positive");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(qx) && $stable(qw))
    else $error("held word changed");

endmodule
